### rtl/integer_divider_signed_unsigned_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the divider checker
// ---------------------------------------------------------------------------
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_UNIT_ASSERT_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IDSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divider assertion failed");

// next-cycle implication, disabled during reset
`define IDSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divider assertion failed");

`endif

### rtl/idsu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idsu_pkg
// shared types and constants of the pipelined restoring divider
// ---------------------------------------------------------------------------
package idsu_pkg;

   // width of the operand and result ports
   localparam int FIELD_WIDTH = 64;

   // default operand width used inside the divider
   localparam int DEFAULT_DATA_WIDTH = 64;

   // command codes
   localparam logic CMD_UNSIGNED = 1'b0;
   localparam logic CMD_SIGNED   = 1'b1;

   // fix-up flags carried along the cell chain
   typedef struct packed {
      logic neg_quo;
      logic neg_rem;
      logic div_zero;
   } ctl_type;

   // one result as held in the output queue
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] quotient;
      logic [FIELD_WIDTH-1:0] remainder;
      logic                   divide_by_zero;
   } result_type;

endpackage

### rtl/integer_divider_signed_unsigned_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_divider_signed_unsigned_unit
// pipelined restoring divider, signed or unsigned, one quotient bit per cell
// ---------------------------------------------------------------------------
// usage:
//   req_ channel carries command (0 unsigned, 1 signed), dividend, divisor;
//   only the low DATA_WIDTH bits of the operands are used.
//   rsp_ channel returns quotient, remainder (upper bits zero) and a
//   divide_by_zero flag; a zero divisor gives zero results with the flag set.
//   signed mode truncates toward zero; the remainder has the dividend's sign.
// a req_ transfer loads the operand stage, then moves through DATA_WIDTH
//   divide cells and one queue write before it shows as rsp_valid.
// throughput: one transfer per cycle while the output queue has room;
//   the operand stage and every cell each hold their own item, so up to
//   DATA_WIDTH + 1 divisions are in flight in the chain at once.
// stall: a two-entry output queue holds finished results; the chain and
//   req_ready stop only when that queue is full.
// reset: synchronous; drops all in-flight items and empties the queue.
// ---------------------------------------------------------------------------
module integer_divider_signed_unsigned_unit #(
   parameter int DATA_WIDTH = idsu_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [idsu_pkg::FIELD_WIDTH-1:0] req_dividend,
   input  logic [idsu_pkg::FIELD_WIDTH-1:0] req_divisor,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [idsu_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic [idsu_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   output logic                             rsp_divide_by_zero
);

   localparam int W = DATA_WIDTH;

   logic                 advance;
   logic                 queue_full;
   logic                 queue_push;
   idsu_pkg::result_type push_data;
   idsu_pkg::result_type rsp_data;

   // operand stage
   logic             is_signed;
   logic [W-1:0]     num_w;
   logic [W-1:0]     den_w;
   logic             num_neg;
   logic             den_neg;
   idsu_pkg::ctl_type pre_ctl_in;
   logic             pre_valid_ff;
   logic [W-1:0]     pre_num_ff;
   logic [W-1:0]     pre_den_ff;
   idsu_pkg::ctl_type pre_ctl_ff;

   // cell chain taps
   logic              chain_valid   [W+1];
   logic [W-1:0]      chain_rem     [W+1];
   logic [W-1:0]      chain_nq      [W+1];
   logic [W-1:0]      chain_divisor [W+1];
   idsu_pkg::ctl_type chain_ctl     [W+1];

   // sign fix-up
   logic [W-1:0]     quo_fix;
   logic [W-1:0]     rem_fix;
   idsu_pkg::ctl_type last_ctl;

   // the whole chain moves while the output queue has room
   assign advance   = ~queue_full;
   assign req_ready = advance;

   // magnitudes and fix-up flags of the incoming operands
   always_comb begin
      is_signed           = (req_command == idsu_pkg::CMD_SIGNED);
      num_w               = req_dividend[W-1:0];
      den_w               = req_divisor[W-1:0];
      num_neg             = is_signed & num_w[W-1];
      den_neg             = is_signed & den_w[W-1];
      pre_ctl_in.neg_quo  = num_neg ^ den_neg;
      pre_ctl_in.neg_rem  = num_neg;
      pre_ctl_in.div_zero = (den_w == '0);
   end

   // operand stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (advance) begin
         pre_valid_ff <= req_valid;
      end
   end

   // operand stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         pre_num_ff <= num_neg ? (~num_w + 1'b1) : num_w;
         pre_den_ff <= den_neg ? (~den_w + 1'b1) : den_w;
         pre_ctl_ff <= pre_ctl_in;
      end
   end

   // head of the chain: partial remainder starts at zero
   assign chain_valid[0]   = pre_valid_ff;
   assign chain_rem[0]     = '0;
   assign chain_nq[0]      = pre_num_ff;
   assign chain_divisor[0] = pre_den_ff;
   assign chain_ctl[0]     = pre_ctl_ff;

   // one cell per quotient bit
   for (genvar i = 0; i < W; i++) begin : g_cell
      idsu_cell #(
         .WIDTH(W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (chain_valid[i]),
         .in_rem      (chain_rem[i]),
         .in_nq       (chain_nq[i]),
         .in_divisor  (chain_divisor[i]),
         .in_ctl      (chain_ctl[i]),
         .out_valid   (chain_valid[i+1]),
         .out_rem     (chain_rem[i+1]),
         .out_nq      (chain_nq[i+1]),
         .out_divisor (chain_divisor[i+1]),
         .out_ctl     (chain_ctl[i+1])
      );
   end

   // sign fix-up and zero-divisor override at the end of the chain
   always_comb begin
      last_ctl = chain_ctl[W];
      quo_fix  = last_ctl.neg_quo ? (~chain_nq[W] + 1'b1) : chain_nq[W];
      rem_fix  = last_ctl.neg_rem ? (~chain_rem[W] + 1'b1) : chain_rem[W];
      if (last_ctl.div_zero) begin
         quo_fix = '0;
         rem_fix = '0;
      end
      push_data.quotient       = idsu_pkg::FIELD_WIDTH'(quo_fix);
      push_data.remainder      = idsu_pkg::FIELD_WIDTH'(rem_fix);
      push_data.divide_by_zero = last_ctl.div_zero;
   end

   assign queue_push = advance & chain_valid[W];

   // finished results wait here for the receiver
   idsu_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_quotient       = rsp_data.quotient;
   assign rsp_remainder      = rsp_data.remainder;
   assign rsp_divide_by_zero = rsp_data.divide_by_zero;

endmodule

### rtl/idsu_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idsu_cell
// one restoring step: shift in a dividend bit, trial subtract, keep or
// restore, and shift the quotient bit into the freed dividend position
// ---------------------------------------------------------------------------
module idsu_cell #(
   parameter int WIDTH = idsu_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [WIDTH-1:0]     in_rem,
   input  logic [WIDTH-1:0]     in_nq,
   input  logic [WIDTH-1:0]     in_divisor,
   input  idsu_pkg::ctl_type    in_ctl,
   output logic                 out_valid,
   output logic [WIDTH-1:0]     out_rem,
   output logic [WIDTH-1:0]     out_nq,
   output logic [WIDTH-1:0]     out_divisor,
   output idsu_pkg::ctl_type    out_ctl
);

   logic             carry;
   logic [WIDTH-1:0] rem_shift;
   logic [WIDTH:0]   diff;
   logic             take;
   logic [WIDTH-1:0] rem_in;
   logic [WIDTH-1:0] nq_in;

   logic             valid_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] nq_ff;
   logic [WIDTH-1:0] divisor_ff;
   idsu_pkg::ctl_type ctl_ff;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      carry     = in_rem[WIDTH-1];
      rem_shift = {in_rem[WIDTH-2:0], in_nq[WIDTH-1]};
      diff      = {1'b0, rem_shift} - {1'b0, in_divisor};
      take      = carry | ~diff[WIDTH];
      rem_in    = take ? diff[WIDTH-1:0] : rem_shift;
      nq_in     = {in_nq[WIDTH-2:0], take};
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff     <= rem_in;
         nq_ff      <= nq_in;
         divisor_ff <= in_divisor;
         ctl_ff     <= in_ctl;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rem     = rem_ff;
   assign out_nq      = nq_ff;
   assign out_divisor = divisor_ff;
   assign out_ctl     = ctl_ff;

endmodule

### rtl/idsu_out_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idsu_out_queue
// two-entry result queue that decouples the cell chain from the receiver
// ---------------------------------------------------------------------------
module idsu_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  idsu_pkg::result_type   push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output idsu_pkg::result_type   rsp_data
);

   idsu_pkg::result_type slot_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 pop;

   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/idsu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idsu_checker
// port-level checks of the divider result channel
// ---------------------------------------------------------------------------
`include "integer_divider_signed_unsigned_unit_assert.svh"

module idsu_checker #(
   parameter int DATA_WIDTH = idsu_pkg::DEFAULT_DATA_WIDTH
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [idsu_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   input logic [idsu_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   input logic                             rsp_divide_by_zero
);

   // a stalled result stays offered
   `IDSU_ASSERT_NEXT(a_rsp_hold, clock, 1'b0, rsp_valid && !rsp_ready && !reset, rsp_valid || reset)

   // zero divisor always comes with zero results
   `IDSU_ASSERT_SAME(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_quotient == '0 && rsp_remainder == '0)

   // no result is offered right after reset
   `IDSU_ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

   // results never carry bits above the operand width
   `IDSU_ASSERT_SAME(a_upper_zero, clock, reset, rsp_valid, (rsp_quotient >> DATA_WIDTH) == '0 && (rsp_remainder >> DATA_WIDTH) == '0)

endmodule

bind integer_divider_signed_unsigned_unit idsu_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_idsu_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_quotient       (rsp_quotient),
   .rsp_remainder      (rsp_remainder),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
